### rtl/tstm_pkg.sv
// Shared types, codes and constants of the task scan timing monitor.
// Used by the channel interfaces and the top level; depends on nothing.
package tstm_pkg;

   localparam int WORD_W    = 32;
   localparam int RESP_W    = 34;
   localparam int ADDR_W    = 5;
   localparam int CSR_W     = 32;

   localparam int PERIOD_W  = 19;
   localparam int WDM_W     = 5;
   localparam int LEVEL_W   = 3;
   localparam int PST_W     = 27;
   localparam int DELAY_W   = 20;

   typedef logic [1:0]        op_type;
   typedef logic [1:0]        stat_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [2:0]        reg_idx_type;

   // Operation codes of a request.
   localparam op_type OP_START  = 2'd0;
   localparam op_type OP_END    = 2'd1;
   localparam op_type OP_RECORD = 2'd2;
   localparam op_type OP_CLEAR  = 2'd3;

   // Status codes of a response.
   localparam stat_type STAT_OK       = 2'd0;
   localparam stat_type STAT_OVERRUN  = 2'd1;
   localparam stat_type STAT_DISABLED = 2'd2;

   // Register indexes on the configuration port.
   localparam reg_idx_type REG_PERIOD    = 3'd0;
   localparam reg_idx_type REG_WDM       = 3'd1;
   localparam reg_idx_type REG_ENABLE    = 3'd2;
   localparam reg_idx_type REG_LEVEL     = 3'd3;
   localparam reg_idx_type REG_PST       = 3'd4;
   localparam reg_idx_type REG_IN_DELAY  = 3'd5;
   localparam reg_idx_type REG_OUT_DELAY = 3'd6;
   localparam reg_idx_type REG_NET       = 3'd7;

   // Integrity level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

   // Register values after reset.
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 19'd10000;
   localparam logic [WDM_W-1:0]    WDM_RST    = 5'd3;
   localparam logic                ENABLE_RST = 1'b1;
   localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 3'd3;
   localparam logic [PST_W-1:0]    PST_RST    = 27'd100000;

   typedef struct packed {
      stat_type                status;
      word_type                execution_time;
      word_type                min_execution;
      word_type                max_execution;
      word_type                avg_execution;
      word_type                healthy_run;
      word_type                overrun_total;
      word_type                completed_scans;
      word_type                last_overrun_scan;
      word_type                max_logic;
      logic                    timing_ok;
      logic [RESP_W-1:0]       max_response;
   } rsp_data_type;

endpackage

### rtl/tstm_if.sv
// Valid/ready channel interfaces of the task scan timing monitor.
// Depends on tstm_pkg for the field types.
interface tstm_req_if;
   import tstm_pkg::*;

   logic     valid;
   logic     ready;
   op_type   operation;
   word_type timestamp;
   word_type input_copy_time;
   word_type logic_time;
   word_type output_copy_time;
   word_type cross_check_time;

   modport source (output valid, output operation, output timestamp,
                   output input_copy_time, output logic_time,
                   output output_copy_time, output cross_check_time,
                   input ready);
   modport sink   (input valid, input operation, input timestamp,
                   input input_copy_time, input logic_time,
                   input output_copy_time, input cross_check_time,
                   output ready);
endinterface

interface tstm_rsp_if;
   import tstm_pkg::*;

   logic              valid;
   logic              ready;
   stat_type          status;
   word_type          execution_time;
   word_type          min_execution;
   word_type          max_execution;
   word_type          avg_execution;
   word_type          healthy_run;
   word_type          overrun_total;
   word_type          completed_scans;
   word_type          last_overrun_scan;
   word_type          max_logic;
   logic              timing_ok;
   logic [RESP_W-1:0] max_response;

   modport source (output valid, output status, output execution_time,
                   output min_execution, output max_execution,
                   output avg_execution, output healthy_run,
                   output overrun_total, output completed_scans,
                   output last_overrun_scan, output max_logic,
                   output timing_ok, output max_response, input ready);
   modport sink   (input valid, input status, input execution_time,
                   input min_execution, input max_execution,
                   input avg_execution, input healthy_run,
                   input overrun_total, input completed_scans,
                   input last_overrun_scan, input max_logic,
                   input timing_ok, input max_response, output ready);
endinterface

### rtl/task_scan_timing_monitor.sv
// Sequence: an accepted request passes through the execute, finish-sum and finish-compare
// states before its response is loaded into the output register; an end request (unless the
// scan count wrapped) first runs the byte-serial multiply and bit-serial restoring divide.
// A new request is taken only once the previous one has left the sequencer.
// Reset is synchronous and active high; it restores the register defaults and clears
// all statistics (minimum to all ones). There is no clearing pass.
//
// Top level of the task scan timing monitor; depends on tstm_pkg and tstm_if.
module task_scan_timing_monitor (
   input  logic                          clock,
   input  logic                          reset,
   tstm_req_if.sink                      req_chan,
   tstm_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tstm_pkg::ADDR_W-1:0]   paddr,
   input  logic [tstm_pkg::CSR_W-1:0]    pwdata,
   output logic [tstm_pkg::CSR_W-1:0]    prdata,
   output logic                          pready
);
   import tstm_pkg::*;

   // Sequencer states.
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_MUL     = 3'd2;
   localparam logic [2:0] S_ADD     = 3'd3;
   localparam logic [2:0] S_DIV     = 3'd4;
   localparam logic [2:0] S_FIN_SUM = 3'd5;
   localparam logic [2:0] S_FIN_CMP = 3'd6;

   localparam int DIGIT_W = 8;

   // Configuration registers.
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [WDM_W-1:0]    wdm_ff, wdm_in;
   logic                enable_ff, enable_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [PST_W-1:0]    pst_ff, pst_in;
   logic [DELAY_W-1:0]  in_delay_ff, in_delay_in;
   logic [DELAY_W-1:0]  out_delay_ff, out_delay_in;
   logic [DELAY_W-1:0]  net_ff, net_in;

   // Captured request.
   op_type   op_ff, op_in;
   word_type ts_ff, ts_in;
   word_type phase_req_ff [4];
   word_type phase_req_in [4];

   // Monitor state.
   word_type next_start_ff, next_start_in;
   word_type scan_start_ff, scan_start_in;
   logic     overrun_flag_ff, overrun_flag_in;
   word_type phase_times_ff [4];
   word_type phase_times_in [4];
   word_type phase_max_ff [4];
   word_type phase_max_in [4];
   word_type scan_cnt_ff, scan_cnt_in;
   word_type ended_ff, ended_in;
   word_type min_ff, min_in;
   word_type max_ff, max_in;
   word_type avg_ff, avg_in;
   word_type healthy_ff, healthy_in;
   word_type overrun_cnt_ff, overrun_cnt_in;
   word_type overrun_scan_ff, overrun_scan_in;
   word_type last_exec_ff, last_exec_in;
   stat_type status_ff, status_in;

   // Average datapath: byte-serial multiply, then bit-serial divide.
   word_type                et_ff, et_in;
   word_type                n_ff, n_in;
   word_type                mdig_ff, mdig_in;
   logic [2*WORD_W-1:0]     prod_ff, prod_in;
   word_type                rem_ff, rem_in;
   word_type                quot_ff, quot_in;
   logic [4:0]              cnt_ff, cnt_in;

   // Verdict and response time.
   logic [RESP_W:0]         resp_sum_ff, resp_sum_in;
   logic [PST_W+3:0]        margin_ff, margin_in;
   logic                    level_ok_ff, level_ok_in;
   logic [RESP_W-1:0]       max_resp_ff, max_resp_in;

   // Control and output stage.
   logic [2:0]              state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic                    csr_write;
   logic                    req_take;
   logic [PERIOD_W+WDM_W-1:0] timeout;
   word_type                late_gap;
   logic                    late;
   word_type                et_calc;
   word_type                n_calc;
   logic [WORD_W+DIGIT_W-1:0] partial;
   logic [2*WORD_W-1:0]     acc;
   logic [WORD_W:0]         trial;
   logic                    trial_ge;
   word_type                trial_rem;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take  = req_chan.valid && req_chan.ready;

   // Read-back of the configuration registers.
   always_comb begin
      case (paddr[ADDR_W-1:2])
         REG_PERIOD:    prdata = CSR_W'(period_ff);
         REG_WDM:       prdata = CSR_W'(wdm_ff);
         REG_ENABLE:    prdata = CSR_W'(enable_ff);
         REG_LEVEL:     prdata = CSR_W'(level_ff);
         REG_PST:       prdata = CSR_W'(pst_ff);
         REG_IN_DELAY:  prdata = CSR_W'(in_delay_ff);
         REG_OUT_DELAY: prdata = CSR_W'(out_delay_ff);
         REG_NET:       prdata = CSR_W'(net_ff);
         default:       prdata = '0;
      endcase
   end

   // Start check: a start is late when it trails the scheduled start by more than
   // the watchdog timeout. A zero scheduled start disables the check, as before the first scan.
   assign timeout  = (PERIOD_W+WDM_W)'(period_ff) * (PERIOD_W+WDM_W)'(wdm_ff);
   assign late_gap = ts_ff - next_start_ff;
   assign late     = (next_start_ff != '0) && (ts_ff > next_start_ff) &&
                     (late_gap > WORD_W'(timeout));

   // When the timer wrapped during the scan, the period stands in for the
   // execution time.
   assign et_calc = (ts_ff >= scan_start_ff) ? (ts_ff - scan_start_ff)
                                             : WORD_W'(period_ff);
   assign n_calc  = ended_ff + 1'b1;

   // One byte of the old scan count times the old average per cycle, most
   // significant byte first.
   assign partial = (WORD_W+DIGIT_W)'(avg_ff) *
                    (WORD_W+DIGIT_W)'(mdig_ff[WORD_W-1 -: DIGIT_W]);
   assign acc     = prod_ff + (2*WORD_W)'(et_ff);

   // Restoring divide step. The remainder stays below the divisor, so the trial
   // value fits one bit more than a word.
   assign trial     = {rem_ff, quot_ff[WORD_W-1]};
   assign trial_ge  = (trial >= {1'b0, n_ff});
   assign trial_rem = trial_ge ? WORD_W'(trial - {1'b0, n_ff}) : trial[WORD_W-1:0];

   always_comb begin
      period_in       = period_ff;
      wdm_in          = wdm_ff;
      enable_in       = enable_ff;
      level_in        = level_ff;
      pst_in          = pst_ff;
      in_delay_in     = in_delay_ff;
      out_delay_in    = out_delay_ff;
      net_in          = net_ff;
      op_in           = op_ff;
      ts_in           = ts_ff;
      phase_req_in    = phase_req_ff;
      next_start_in   = next_start_ff;
      scan_start_in   = scan_start_ff;
      overrun_flag_in = overrun_flag_ff;
      phase_times_in  = phase_times_ff;
      phase_max_in    = phase_max_ff;
      scan_cnt_in     = scan_cnt_ff;
      ended_in        = ended_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      avg_in          = avg_ff;
      healthy_in      = healthy_ff;
      overrun_cnt_in  = overrun_cnt_ff;
      overrun_scan_in = overrun_scan_ff;
      last_exec_in    = last_exec_ff;
      status_in       = status_ff;
      et_in           = et_ff;
      n_in            = n_ff;
      mdig_in         = mdig_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      cnt_in          = cnt_ff;
      resp_sum_in     = resp_sum_ff;
      margin_in       = margin_ff;
      level_ok_in     = level_ok_ff;
      max_resp_in     = max_resp_ff;
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in     = rsp_data_ff;

      // Writes must arrive only while the sequencer is idle; the block itself does not enforce it.
      if (csr_write) begin
         case (paddr[ADDR_W-1:2])
            REG_PERIOD:    period_in    = pwdata[PERIOD_W-1:0];
            REG_WDM:       wdm_in       = pwdata[WDM_W-1:0];
            REG_ENABLE:    enable_in    = pwdata[0];
            REG_LEVEL:     level_in     = pwdata[LEVEL_W-1:0];
            REG_PST:       pst_in       = pwdata[PST_W-1:0];
            REG_IN_DELAY:  in_delay_in  = pwdata[DELAY_W-1:0];
            REG_OUT_DELAY: out_delay_in = pwdata[DELAY_W-1:0];
            REG_NET:       net_in       = pwdata[DELAY_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in           = req_chan.operation;
               ts_in           = req_chan.timestamp;
               phase_req_in[0] = req_chan.input_copy_time;
               phase_req_in[1] = req_chan.logic_time;
               phase_req_in[2] = req_chan.output_copy_time;
               phase_req_in[3] = req_chan.cross_check_time;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = STAT_OK;
            state_in  = S_FIN_SUM;
            case (op_ff)
               OP_START: begin
                  if (!enable_ff) begin
                     status_in = STAT_DISABLED;
                  end else if (late) begin
                     overrun_cnt_in  = overrun_cnt_ff + 1'b1;
                     overrun_scan_in = scan_cnt_ff;
                     overrun_flag_in = 1'b1;
                     status_in       = STAT_OVERRUN;
                  end else begin
                     scan_start_in   = ts_ff;
                     overrun_flag_in = 1'b0;
                     next_start_in   = ts_ff + WORD_W'(period_ff);
                  end
               end
               OP_END: begin
                  last_exec_in = et_calc;
                  et_in        = et_calc;
                  ended_in     = n_calc;
                  scan_cnt_in  = scan_cnt_ff + 1'b1;
                  if (et_calc > max_ff) begin
                     max_in = et_calc;
                  end
                  if (et_calc < min_ff) begin
                     min_in = et_calc;
                  end
                  for (int i = 0; i < 4; i++) begin
                     if (phase_times_ff[i] > phase_max_ff[i]) begin
                        phase_max_in[i] = phase_times_ff[i];
                     end
                  end
                  healthy_in = overrun_flag_ff ? '0 : healthy_ff + 1'b1;
                  n_in       = n_calc;
                  mdig_in    = ended_ff;
                  prod_in    = '0;
                  cnt_in     = '0;
                  // A wrapped scan count restarts the average at this scan.
                  if (n_calc == '0) begin
                     avg_in = et_calc;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               OP_RECORD: begin
                  phase_times_in = phase_req_ff;
               end
               OP_CLEAR: begin
                  max_in     = '0;
                  min_in     = '1;
                  avg_in     = '0;
                  healthy_in = '0;
                  for (int i = 0; i < 4; i++) begin
                     phase_max_in[i] = '0;
                  end
               end
               default: ;
            endcase
         end
         S_MUL: begin
            prod_in = {prod_ff[2*WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} +
                      (2*WORD_W)'(partial);
            mdig_in = {mdig_ff[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            rem_in   = acc[2*WORD_W-1:WORD_W];
            quot_in  = acc[WORD_W-1:0];
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_rem;
            quot_in = {quot_ff[WORD_W-2:0], trial_ge};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               avg_in   = {quot_ff[WORD_W-2:0], trial_ge};
               state_in = S_FIN_SUM;
            end
         end
         S_FIN_SUM: begin
            // Verdict response excludes the module delays; the reported response
            // time includes them and only the cross-check maximum.
            resp_sum_in = (RESP_W+1)'({period_ff, 1'b0}) +
                          (RESP_W+1)'(phase_max_ff[0]) +
                          (RESP_W+1)'(phase_max_ff[2]) +
                          (RESP_W+1)'(phase_max_ff[3]);
            max_resp_in = RESP_W'({period_ff, 1'b0}) + RESP_W'(in_delay_ff) +
                          RESP_W'(out_delay_ff) + RESP_W'(net_ff) +
                          RESP_W'(phase_max_ff[3]);
            level_ok_in = 1'b1;
            case (level_ff)
               LEVEL_1: margin_in = (PST_W+4)'({pst_ff, 3'b000}) +
                                    (PST_W+4)'({pst_ff, 1'b0});
               LEVEL_2: margin_in = (PST_W+4)'({pst_ff, 2'b00}) + (PST_W+4)'(pst_ff);
               LEVEL_3: margin_in = (PST_W+4)'({pst_ff, 1'b0});
               LEVEL_4: margin_in = (PST_W+4)'(pst_ff);
               default: begin
                  margin_in   = '0;
                  level_ok_in = 1'b0;
               end
            endcase
            state_in = S_FIN_CMP;
         end
         S_FIN_CMP: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.status            = status_ff;
               rsp_data_in.execution_time    = last_exec_ff;
               rsp_data_in.min_execution     = min_ff;
               rsp_data_in.max_execution     = max_ff;
               rsp_data_in.avg_execution     = avg_ff;
               rsp_data_in.healthy_run       = healthy_ff;
               rsp_data_in.overrun_total     = overrun_cnt_ff;
               rsp_data_in.completed_scans   = ended_ff;
               rsp_data_in.last_overrun_scan = overrun_scan_ff;
               rsp_data_in.max_logic         = phase_max_ff[1];
               rsp_data_in.timing_ok         = level_ok_ff &&
                                               (resp_sum_ff <= (RESP_W+1)'(margin_ff));
               rsp_data_in.max_response      = max_resp_ff;
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and statistics registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= PERIOD_RST;
         wdm_ff          <= WDM_RST;
         enable_ff       <= ENABLE_RST;
         level_ff        <= LEVEL_RST;
         pst_ff          <= PST_RST;
         in_delay_ff     <= '0;
         out_delay_ff    <= '0;
         net_ff          <= '0;
         next_start_ff   <= '0;
         scan_start_ff   <= '0;
         overrun_flag_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            phase_times_ff[i] <= '0;
            phase_max_ff[i]   <= '0;
         end
         scan_cnt_ff     <= '0;
         ended_ff        <= '0;
         min_ff          <= '1;
         max_ff          <= '0;
         avg_ff          <= '0;
         healthy_ff      <= '0;
         overrun_cnt_ff  <= '0;
         overrun_scan_ff <= '0;
         last_exec_ff    <= '0;
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         period_ff       <= period_in;
         wdm_ff          <= wdm_in;
         enable_ff       <= enable_in;
         level_ff        <= level_in;
         pst_ff          <= pst_in;
         in_delay_ff     <= in_delay_in;
         out_delay_ff    <= out_delay_in;
         net_ff          <= net_in;
         next_start_ff   <= next_start_in;
         scan_start_ff   <= scan_start_in;
         overrun_flag_ff <= overrun_flag_in;
         phase_times_ff  <= phase_times_in;
         phase_max_ff    <= phase_max_in;
         scan_cnt_ff     <= scan_cnt_in;
         ended_ff        <= ended_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
         avg_ff          <= avg_in;
         healthy_ff      <= healthy_in;
         overrun_cnt_ff  <= overrun_cnt_in;
         overrun_scan_ff <= overrun_scan_in;
         last_exec_ff    <= last_exec_in;
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ts_ff        <= ts_in;
      phase_req_ff <= phase_req_in;
      status_ff    <= status_in;
      et_ff        <= et_in;
      n_ff         <= n_in;
      mdig_ff      <= mdig_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      resp_sum_ff  <= resp_sum_in;
      margin_ff    <= margin_in;
      level_ok_ff  <= level_ok_in;
      max_resp_ff  <= max_resp_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_data_ff.status;
   assign rsp_chan.execution_time    = rsp_data_ff.execution_time;
   assign rsp_chan.min_execution     = rsp_data_ff.min_execution;
   assign rsp_chan.max_execution     = rsp_data_ff.max_execution;
   assign rsp_chan.avg_execution     = rsp_data_ff.avg_execution;
   assign rsp_chan.healthy_run       = rsp_data_ff.healthy_run;
   assign rsp_chan.overrun_total     = rsp_data_ff.overrun_total;
   assign rsp_chan.completed_scans   = rsp_data_ff.completed_scans;
   assign rsp_chan.last_overrun_scan = rsp_data_ff.last_overrun_scan;
   assign rsp_chan.max_logic         = rsp_data_ff.max_logic;
   assign rsp_chan.timing_ok         = rsp_data_ff.timing_ok;
   assign rsp_chan.max_response      = rsp_data_ff.max_response;

   // The divide remainder must stay below the divisor, or the quotient overflows.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < n_ff))
      else $error("divide remainder not below divisor");

   // Once any scan has set the minimum, it cannot exceed the maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (min_ff != '1) |-> (min_ff <= max_ff))
      else $error("minimum execution time above maximum");

   // The multiply takes exactly four byte steps before the final add.
   a_mul_four_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && cnt_ff[1:0] == 2'd3) |=> (state_ff == S_ADD))
      else $error("multiply did not hand over to the add after four steps");

   // A response is only loaded while leaving the finish state.
   a_load_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN_CMP && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request did not reach the output register");

endmodule

### tb/sv/task_scan_timing_checker.sv
`timescale 1ns / 1ps
// Checker for the task scan timing monitor: follows register writes and requests,
// predicts every response and compares it field by field. Depends on tstm_pkg, tstm_if.
module task_scan_timing_checker
   import tstm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tstm_req_if                req_chan,
   tstm_rsp_if                rsp_chan,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]   pwdata,
   input  logic               pready,
   output int unsigned        mismatches,
   output int unsigned        outstanding
);

   // Register copies.
   logic [PERIOD_W-1:0] cfg_period;
   logic [WDM_W-1:0]    cfg_wdm;
   logic                cfg_enable;
   logic [LEVEL_W-1:0]  cfg_level;
   logic [PST_W-1:0]    cfg_pst;
   logic [DELAY_W-1:0]  cfg_in_dly;
   logic [DELAY_W-1:0]  cfg_out_dly;
   logic [DELAY_W-1:0]  cfg_net;

   // Monitor state.
   word_type sched_next;
   word_type scan_begin;
   logic     late_flag;
   word_type phase_now [4];
   word_type phase_peak [4];
   word_type scan_num;
   word_type ends_seen;
   word_type exec_min;
   word_type exec_max;
   word_type exec_avg;
   word_type healthy;
   word_type overruns;
   word_type overrun_at;
   word_type exec_last;

   rsp_data_type due_reports [$];
   rsp_data_type want;

   function automatic void clear_stats();
      exec_max = '0;
      exec_min = '1;
      exec_avg = '0;
      healthy  = '0;
      for (int i = 0; i < 4; i++) phase_peak[i] = '0;
   endfunction

   function automatic void restore_defaults();
      cfg_period  = PERIOD_RST;
      cfg_wdm     = WDM_RST;
      cfg_enable  = ENABLE_RST;
      cfg_level   = LEVEL_RST;
      cfg_pst     = PST_RST;
      cfg_in_dly  = '0;
      cfg_out_dly = '0;
      cfg_net     = '0;
      sched_next  = '0;
      scan_begin  = '0;
      late_flag   = 1'b0;
      scan_num    = '0;
      ends_seen   = '0;
      overruns    = '0;
      overrun_at  = '0;
      exec_last   = '0;
      for (int i = 0; i < 4; i++) phase_now[i] = '0;
      clear_stats();
   endfunction

   function automatic void load_register(reg_idx_type idx, logic [CSR_W-1:0] data);
      case (idx)
         REG_PERIOD:    cfg_period  = data[PERIOD_W-1:0];
         REG_WDM:       cfg_wdm     = data[WDM_W-1:0];
         REG_ENABLE:    cfg_enable  = data[0];
         REG_LEVEL:     cfg_level   = data[LEVEL_W-1:0];
         REG_PST:       cfg_pst     = data[PST_W-1:0];
         REG_IN_DELAY:  cfg_in_dly  = data[DELAY_W-1:0];
         REG_OUT_DELAY: cfg_out_dly = data[DELAY_W-1:0];
         REG_NET:       cfg_net     = data[DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   // A start is late only once a schedule exists and the lag exceeds the watchdog.
   function automatic stat_type start_scan(word_type ts);
      logic [63:0] timeout;
      word_type    lag;
      if (!cfg_enable) return STAT_DISABLED;
      timeout = 64'(cfg_period) * 64'(cfg_wdm);
      lag     = ts - sched_next;
      if (sched_next != '0 && ts > sched_next && 64'(lag) > timeout) begin
         overruns   = overruns + 1;
         overrun_at = scan_num;
         late_flag  = 1'b1;
         return STAT_OVERRUN;
      end
      scan_begin = ts;
      late_flag  = 1'b0;
      sched_next = ts + word_type'(cfg_period);
      return STAT_OK;
   endfunction

   function automatic void end_scan(word_type ts);
      word_type    et;
      word_type    prior;
      logic [63:0] acc;
      // A timer that wrapped since the start counts as one full period.
      et = (ts >= scan_begin) ? ts - scan_begin : word_type'(cfg_period);
      exec_last = et;
      ends_seen = ends_seen + 1;
      scan_num  = scan_num + 1;
      if (et > exec_max) exec_max = et;
      if (et < exec_min) exec_min = et;
      if (ends_seen == '0) begin
         exec_avg = et;
      end else begin
         prior    = ends_seen - 1;
         acc      = 64'(exec_avg) * 64'(prior) + 64'(et);
         exec_avg = word_type'(acc / 64'(ends_seen));
      end
      for (int i = 0; i < 4; i++)
         if (phase_now[i] > phase_peak[i]) phase_peak[i] = phase_now[i];
      healthy = late_flag ? '0 : healthy + 1;
   endfunction

   function automatic logic level_met();
      logic [63:0] reach;
      logic [63:0] margin;
      reach = 64'(cfg_period) * 64'd2 + 64'(phase_peak[0]) + 64'(phase_peak[2]) +
              64'(phase_peak[3]);
      case (cfg_level)
         LEVEL_1: margin = 64'(cfg_pst) * 64'd10;
         LEVEL_2: margin = 64'(cfg_pst) * 64'd5;
         LEVEL_3: margin = 64'(cfg_pst) * 64'd2;
         LEVEL_4: margin = 64'(cfg_pst);
         default: return 1'b0;
      endcase
      return reach <= margin;
   endfunction

   function automatic rsp_data_type monitor_op(op_type op, word_type ts, word_type ph0,
                                               word_type ph1, word_type ph2, word_type ph3);
      rsp_data_type r;
      stat_type     st;
      logic [63:0]  span;
      st = STAT_OK;
      case (op)
         OP_START:  st = start_scan(ts);
         OP_END:    end_scan(ts);
         OP_RECORD: begin
            phase_now[0] = ph0;
            phase_now[1] = ph1;
            phase_now[2] = ph2;
            phase_now[3] = ph3;
         end
         default:   clear_stats();
      endcase
      span = 64'(cfg_period) * 64'd2 + 64'(cfg_in_dly) + 64'(cfg_out_dly) + 64'(cfg_net) +
             64'(phase_peak[3]);
      r.status            = st;
      r.execution_time    = exec_last;
      r.min_execution     = exec_min;
      r.max_execution     = exec_max;
      r.avg_execution     = exec_avg;
      r.healthy_run       = healthy;
      r.overrun_total     = overruns;
      r.completed_scans   = ends_seen;
      r.last_overrun_scan = overrun_at;
      r.max_logic         = phase_peak[1];
      r.timing_ok         = level_met();
      r.max_response      = span[RESP_W-1:0];
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: response field %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         due_reports.delete();
         mismatches = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (due_reports.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual status %0h",
                        $time, rsp_chan.status);
               mismatches++;
            end else begin
               want = due_reports.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("execution_time", want.execution_time, rsp_chan.execution_time);
               check_field("min_execution", want.min_execution, rsp_chan.min_execution);
               check_field("max_execution", want.max_execution, rsp_chan.max_execution);
               check_field("avg_execution", want.avg_execution, rsp_chan.avg_execution);
               check_field("healthy_run", want.healthy_run, rsp_chan.healthy_run);
               check_field("overrun_total", want.overrun_total, rsp_chan.overrun_total);
               check_field("completed_scans", want.completed_scans, rsp_chan.completed_scans);
               check_field("last_overrun_scan", want.last_overrun_scan,
                           rsp_chan.last_overrun_scan);
               check_field("max_logic", want.max_logic, rsp_chan.max_logic);
               check_field("timing_ok", want.timing_ok, rsp_chan.timing_ok);
               check_field("max_response", want.max_response, rsp_chan.max_response);
            end
         end
         if (psel && penable && pwrite && pready)
            load_register(paddr[ADDR_W-1:2], pwdata);
         if (req_chan.valid && req_chan.ready)
            due_reports.push_back(monitor_op(req_chan.operation, req_chan.timestamp,
                                             req_chan.input_copy_time, req_chan.logic_time,
                                             req_chan.output_copy_time,
                                             req_chan.cross_check_time));
      end
      outstanding <= due_reports.size();
   end

endmodule

### tb/sv/tb_task_scan_timing_monitor.sv
`timescale 1ns / 1ps
// Top of the task scan timing monitor testbench: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on tstm_pkg, tstm_if, the checker.
module tb_task_scan_timing_monitor;
   import tstm_pkg::*;

   localparam int          PHASES          = 8;
   localparam int          ITEMS_PER_PHASE = 72;
   localparam int          HOLD_PHASE      = 6;
   localparam int          PAUSE_PHASE     = 5;
   localparam int unsigned HOLD_CYCLES     = 400;
   localparam int unsigned QUIET_LIMIT     = 4000;
   localparam int unsigned DRAIN_CYCLES    = 60;
   // Integrity level code that selects no margin at all.
   localparam logic [LEVEL_W-1:0] LEVEL_NONE = '0;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [CSR_W-1:0]  pwdata;
   logic [CSR_W-1:0]  prdata;
   logic              pready;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned quiet_cycles;

   // The receiver picks this up and then keeps ready low for a long stretch.
   bit rsp_hold_req;
   bit req_quiet;

   // The stimulus keeps its own view of the schedule so that it can aim starts
   // on time, early, at the watchdog boundary or late.
   word_type            sched_next;
   word_type            scan_from;
   logic [PERIOD_W-1:0] cur_period;
   logic [63:0]         cur_timeout;
   logic                cur_enable;

   tstm_req_if req_bus ();
   tstm_rsp_if rsp_bus ();

   task_scan_timing_monitor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   task_scan_timing_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any handshake or register write counts as progress. A long run of
   // cycles without any of them means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("task_scan_timing_monitor verification failed");
            $finish;
         end
      end
   end

   // Mirror of the start rule, used only to steer timestamps. A start that the
   // block will reject leaves the schedule where it was.
   function automatic void track_start(word_type ts);
      word_type lag;
      if (!cur_enable) return;
      lag = ts - sched_next;
      if (sched_next != '0 && ts > sched_next && 64'(lag) > cur_timeout) return;
      scan_from  = ts;
      sched_next = ts + word_type'(cur_period);
   endfunction

   // Offers one request after a random gap and returns at the falling edge that
   // follows its acceptance, with valid still high.
   task automatic send_item(op_type op, word_type ts, word_type t_in, word_type t_logic,
                            word_type t_out, word_type t_cross);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.operation        <= op;
      req_bus.timestamp        <= ts;
      req_bus.input_copy_time  <= t_in;
      req_bus.logic_time       <= t_logic;
      req_bus.output_copy_time <= t_out;
      req_bus.cross_check_time <= t_cross;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      if (op == OP_START) track_start(ts);
      // Now and then switch between gapped and back-to-back offering.
      if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
   endtask

   // Stops offering and waits until every predicted response has been taken.
   task automatic drain_all();
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // One APB write: setup cycle, then access cycle. Bits above the register
   // width are filled at random, since the block must drop them.
   task automatic csr_write(reg_idx_type idx, logic [CSR_W-1:0] value, int unsigned width);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value | (CSR_W'($urandom()) << width);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Register settings of each phase: the lower and upper ends of the ranges,
   // full register widths, a disabled task, a zero period and watchdog with an
   // invalid integrity level, and random settings in between.
   task automatic apply_setting(int which);
      logic [PERIOD_W-1:0] period;
      logic [WDM_W-1:0]    wdm;
      logic                enable;
      logic [LEVEL_W-1:0]  level;
      logic [PST_W-1:0]    pst;
      logic [DELAY_W-1:0]  in_dly;
      logic [DELAY_W-1:0]  out_dly;
      logic [DELAY_W-1:0]  net;
      period  = PERIOD_W'($urandom_range(1000, 500000));
      wdm     = WDM_W'($urandom_range(1, 16));
      enable  = 1'b1;
      level   = LEVEL_W'($urandom_range(LEVEL_1, LEVEL_4));
      // Keep the safety time near the response time so the verdict goes both ways.
      pst     = PST_W'($urandom_range(0, 4 * period));
      in_dly  = DELAY_W'($urandom_range(0, 1000000));
      out_dly = DELAY_W'($urandom_range(0, 1000000));
      net     = DELAY_W'($urandom_range(0, 1000000));
      case (which)
         0: begin
            period = 19'd1000;
            wdm    = 5'd1;
            level  = LEVEL_1;
            pst    = '0;
            in_dly = '0;
            out_dly = '0;
            net    = '0;
         end
         1: begin
            period  = 19'd500000;
            wdm     = 5'd16;
            level   = LEVEL_4;
            pst     = 27'd100000000;
            in_dly  = 20'd1000000;
            out_dly = 20'd1000000;
            net     = 20'd1000000;
         end
         2: begin
            period  = '1;
            wdm     = '1;
            level   = LEVEL_NONE;
            pst     = '1;
            in_dly  = '1;
            out_dly = '1;
            net     = '1;
         end
         3: enable = 1'b0;
         4: begin
            period = '0;
            wdm    = '0;
            level  = LEVEL_W'($urandom_range(LEVEL_4 + 1, 7));
         end
         default: ;
      endcase
      csr_write(REG_PERIOD, CSR_W'(period), PERIOD_W);
      csr_write(REG_WDM, CSR_W'(wdm), WDM_W);
      csr_write(REG_ENABLE, CSR_W'(enable), 1);
      csr_write(REG_LEVEL, CSR_W'(level), LEVEL_W);
      csr_write(REG_PST, CSR_W'(pst), PST_W);
      csr_write(REG_IN_DELAY, CSR_W'(in_dly), DELAY_W);
      csr_write(REG_OUT_DELAY, CSR_W'(out_dly), DELAY_W);
      csr_write(REG_NET, CSR_W'(net), DELAY_W);
      cur_period  = period;
      cur_timeout = 64'(period) * 64'(wdm);
      cur_enable  = enable;
   endtask

   function automatic word_type phase_value();
      return ($urandom_range(0, 7) == 0) ? word_type'($urandom()) :
                                           word_type'($urandom_range(0, 2 * cur_period + 1));
   endfunction

   // A well-formed scan: a start aimed at the schedule, usually a record of the
   // phase times, then an end whose timestamp usually follows the start.
   task automatic scan_cycle(output int sent);
      word_type    ts;
      word_type    per32;
      word_type    tmo32;
      int unsigned pick;
      per32 = word_type'(cur_period);
      tmo32 = cur_timeout[WORD_W-1:0];
      pick  = $urandom_range(0, 9);
      if (pick <= 5)
         ts = sched_next + word_type'($urandom_range(0, tmo32));
      else if (pick == 6)
         ts = sched_next - word_type'($urandom_range(0, per32));
      else if (pick == 7)
         ts = sched_next + tmo32 + 1 + word_type'($urandom_range(0, per32));
      else if (pick == 8)
         ts = sched_next + tmo32;
      else
         ts = $urandom();
      send_item(OP_START, ts, $urandom(), $urandom(), $urandom(), $urandom());
      sent = 1;
      if ($urandom_range(0, 9) < 7) begin
         send_item(OP_RECORD, $urandom(), phase_value(), phase_value(), phase_value(),
                   phase_value());
         sent++;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6)
         ts = scan_from + word_type'($urandom_range(0, per32));
      else if (pick == 7)
         ts = scan_from - word_type'($urandom_range(1, 5000));
      else if (pick == 8)
         ts = $urandom();
      else
         ts = scan_from;
      send_item(OP_END, ts, $urandom(), $urandom(), $urandom(), $urandom());
      sent++;
   endtask

   // Random part of one phase: mostly complete scans, some statistics clears and
   // some requests with every field random.
   task automatic run_random(int phase);
      int          count;
      int          sent;
      int unsigned roll;
      bit          held;
      bit          paused;
      count  = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (count < ITEMS_PER_PHASE) begin
         // Long receiver hold while requests keep coming, so the block backs up.
         if (phase == HOLD_PHASE && count >= 10 && !held) begin
            held         = 1'b1;
            rsp_hold_req = 1'b1;
         end
         // Sender pause until every response is back.
         if (phase == PAUSE_PHASE && count >= 30 && !paused) begin
            paused = 1'b1;
            drain_all();
         end
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            send_item(op_type'($urandom_range(OP_START, OP_CLEAR)), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom());
            count++;
         end else if (roll < 20) begin
            send_item(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            count++;
         end else begin
            scan_cycle(sent);
            count += sent;
         end
      end
   endtask

   // Response side: a random stall before each response, stretches without
   // stalls, and one long hold when requested.
   initial begin
      bit          rsp_quiet;
      int unsigned stall;
      rsp_quiet = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            stall        = HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end else begin
            stall = rsp_quiet ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
         if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
      end
   end

   initial begin
      reset                    = 1'b1;
      psel                     = 1'b0;
      penable                  = 1'b0;
      pwrite                   = 1'b0;
      paddr                    = '0;
      pwdata                   = '0;
      req_bus.valid            = 1'b0;
      req_bus.operation        = OP_START;
      req_bus.timestamp        = '0;
      req_bus.input_copy_time  = '0;
      req_bus.logic_time       = '0;
      req_bus.output_copy_time = '0;
      req_bus.cross_check_time = '0;
      rsp_bus.ready            = 1'b0;
      rsp_hold_req             = 1'b0;
      req_quiet                = 1'b0;
      sched_next               = '0;
      scan_from                = '0;
      cur_period               = PERIOD_RST;
      cur_timeout              = 64'(PERIOD_RST) * 64'(WDM_RST);
      cur_enable               = ENABLE_RST;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part, with the register values left by reset (period 10000,
      // watchdog timeout 30000).
      // An end before any start measures from time zero; the clear restores the
      // empty minimum.
      send_item(OP_END, '0, '0, '0, '0, '0);
      send_item(OP_CLEAR, '0, '0, '0, '0, '0);
      // This start puts the next scheduled start at exactly zero, so the one after
      // it cannot be late; that one wraps the schedule to 0x710.
      send_item(OP_START, 32'hFFFF_D8F0, '0, '0, '0, '0);
      send_item(OP_START, 32'hFFFF_E000, '0, '0, '0, '0);
      send_item(OP_RECORD, '1, '1, '1, '1, '1);
      // End below the start timestamp: the timer wrapped, so one period is counted.
      send_item(OP_END, 32'h0000_0100, '0, '0, '0, '0);
      // One microsecond past the watchdog is an overrun, and the next end breaks
      // the healthy run.
      send_item(OP_START, 32'd31809, '0, '0, '0, '0);
      send_item(OP_END, 32'd40000, '0, '0, '0, '0);
      // Exactly at the watchdog boundary the start is still accepted.
      send_item(OP_START, 32'd31808, '0, '0, '0, '0);
      send_item(OP_RECORD, '0, '0, '0, '0, '0);
      send_item(OP_END, '1, '1, '1, '1, '1);
      send_item(OP_CLEAR, '1, '1, '1, '1, '1);
      // A start right on schedule, alternating phase extremes, and a zero-length scan.
      send_item(OP_START, 32'd41808, '0, '0, '0, '0);
      send_item(OP_RECORD, '0, '0, '1, '0, '1);
      send_item(OP_END, 32'd41808, '0, '0, '0, '0);
      // An early start is never late.
      send_item(OP_START, 32'd100, '0, '0, '0, '0);
      send_item(OP_RECORD, '0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(OP_END, 32'd200, '0, '0, '0, '0);

      // Random part: new register settings in each phase, written while idle.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_all();
         apply_setting(phase);
         run_random(phase);
      end

      drain_all();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("task_scan_timing_monitor verification clean");
      else
         $display("task_scan_timing_monitor verification failed");
      $finish;
   end

endmodule
